[src/tcfam_pkg.sv]
// Shared types and codes for the two-class FIFO with age-ordered merge.
package tcfam_pkg;

    localparam int ValueWidth = 32;
    localparam int TagWidth   = 32;
    localparam int KindWidth  = 3;

    localparam logic [KindWidth-1:0] KIND_ADD       = 3'd0;
    localparam logic [KindWidth-1:0] KIND_DRAIN_ALL = 3'd1;
    localparam logic [KindWidth-1:0] KIND_DRAIN_CAT = 3'd2;
    localparam logic [KindWidth-1:0] KIND_DRAIN_DOG = 3'd3;
    localparam logic [KindWidth-1:0] KIND_STATUS    = 3'd4;

    localparam logic RESULT_ENTRY  = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    localparam logic CLASS_DOG = 1'b0;
    localparam logic CLASS_CAT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add;
        logic status_req;
        logic pop_cat;
        logic pop_dog;
        logic last;
    } t_cmd;

    // Queue status from the datapath to the controller.
    typedef struct packed {
        logic cat_empty;
        logic dog_empty;
        logic cat_one;
        logic dog_one;
        logic dog_older;
    } t_stat;

endpackage

[src/two_class_fifo_age_merge_unit.sv]
// Top level of the two-class FIFO with age-ordered merge.
// Commands are taken when start is high and busy is low. An add or a status
// command leaves busy low; a status beat appears on the cycle after the
// command. A drain raises busy from the cycle after it is taken and pops one
// entry per cycle from the queue memories, holding busy until its final entry
// is popped (with nothing to pop it returns to idle without a beat), and
// delivers its beats back to back, the first on the cycle after the first busy
// cycle. Each beat is on the output ports for exactly one cycle, marked by
// o_valid, and must be captured then; o_last marks the final beat of a
// command. Undefined command codes are ignored.
module two_class_fifo_age_merge_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tcfam_pkg::KindWidth-1:0]     i_kind,
    input  logic                                i_item_class,
    input  logic signed [tcfam_pkg::ValueWidth-1:0] i_item_value,
    output logic                                o_valid,
    output logic                                o_result_kind,
    output logic                                o_out_class,
    output logic signed [tcfam_pkg::ValueWidth-1:0] o_out_value,
    output logic                                o_last,
    output logic                                o_both_empty,
    output logic                                o_cat_queue_empty,
    output logic                                o_dog_queue_empty,
    output logic                                o_overflow_seen
);

    tcfam_pkg::t_cmd  cmd;
    tcfam_pkg::t_stat stat;

    tcfam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tcfam_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_item_class      (i_item_class),
        .i_item_value      (i_item_value),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_result_kind     (o_result_kind),
        .o_out_class       (o_out_class),
        .o_out_value       (o_out_value),
        .o_last            (o_last),
        .o_both_empty      (o_both_empty),
        .o_cat_queue_empty (o_cat_queue_empty),
        .o_dog_queue_empty (o_dog_queue_empty),
        .o_overflow_seen   (o_overflow_seen)
    );

endmodule

[src/tcfam_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tcfam_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/tcfam_ctrl.sv]
// Controller: accepts commands, sequences drains and picks the entry to pop each cycle.
module tcfam_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tcfam_pkg::KindWidth-1:0] i_kind,
    input  tcfam_pkg::t_stat              i_stat,
    output tcfam_pkg::t_cmd               o_cmd,
    output logic                          o_busy
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        MODE_ALL,
        MODE_CAT,
        MODE_DOG
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    logic   accept;
    logic   pop_cat;
    logic   pop_dog;
    logic   last;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        pop_cat = 1'b0;
        pop_dog = 1'b0;
        last    = 1'b0;
        if (r_state == ST_DRAIN) begin
            case (r_mode)
                MODE_ALL: begin
                    // The dog head goes first only when its tag is strictly older.
                    pop_dog = !i_stat.dog_empty && (i_stat.cat_empty || i_stat.dog_older);
                    pop_cat = !i_stat.cat_empty && !pop_dog;
                    last    = (pop_dog && i_stat.dog_one && i_stat.cat_empty) ||
                              (pop_cat && i_stat.cat_one && i_stat.dog_empty);
                end
                MODE_CAT: begin
                    pop_cat = !i_stat.cat_empty;
                    last    = pop_cat && i_stat.cat_one;
                end
                MODE_DOG: begin
                    pop_dog = !i_stat.dog_empty;
                    last    = pop_dog && i_stat.dog_one;
                end
                default: begin
                    pop_cat = 1'b0;
                    pop_dog = 1'b0;
                    last    = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        tcfam_pkg::KIND_DRAIN_ALL: begin
                            n_state = ST_DRAIN;
                            n_mode  = MODE_ALL;
                        end
                        tcfam_pkg::KIND_DRAIN_CAT: begin
                            n_state = ST_DRAIN;
                            n_mode  = MODE_CAT;
                        end
                        tcfam_pkg::KIND_DRAIN_DOG: begin
                            n_state = ST_DRAIN;
                            n_mode  = MODE_DOG;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (!(pop_cat || pop_dog) || last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_ALL;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_cmd.add        = accept && (i_kind == tcfam_pkg::KIND_ADD);
    assign o_cmd.status_req = accept && (i_kind == tcfam_pkg::KIND_STATUS);
    assign o_cmd.pop_cat    = pop_cat;
    assign o_cmd.pop_dog    = pop_dog;
    assign o_cmd.last       = last;

endmodule

[src/tcfam_dp.sv]
// Datapath: the two queue memories, pointers, arrival counter and the result register.
module tcfam_dp #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcfam_pkg::t_cmd                     i_cmd,
    input  logic                                i_item_class,
    input  logic signed [tcfam_pkg::ValueWidth-1:0] i_item_value,
    output tcfam_pkg::t_stat                    o_stat,
    output logic                                o_valid,
    output logic                                o_result_kind,
    output logic                                o_out_class,
    output logic signed [tcfam_pkg::ValueWidth-1:0] o_out_value,
    output logic                                o_last,
    output logic                                o_both_empty,
    output logic                                o_cat_queue_empty,
    output logic                                o_dog_queue_empty,
    output logic                                o_overflow_seen
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = tcfam_pkg::TagWidth + tcfam_pkg::ValueWidth;

    logic [AW-1:0] r_cat_head, n_cat_head;
    logic [AW-1:0] r_dog_head, n_dog_head;
    logic [CW-1:0] r_cat_count, n_cat_count;
    logic [CW-1:0] r_dog_count, n_dog_count;
    logic [tcfam_pkg::TagWidth-1:0] r_arrival;
    logic          r_overflow;

    logic          cat_full, dog_full;
    logic          wr_cat, wr_dog;
    logic [AW-1:0] cat_wr_addr, dog_wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] cat_rd, dog_rd;

    logic          r_valid;
    logic          r_result_kind;
    logic          r_out_class;
    logic signed [tcfam_pkg::ValueWidth-1:0] r_out_value;
    logic          r_last;
    logic          r_both_empty;
    logic          r_cat_empty;
    logic          r_dog_empty;
    logic          r_overflow_seen;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
        next_ptr = (ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Tail slot is head plus count, wrapped once; the sum stays below twice the depth.
    function automatic logic [AW-1:0] tail_slot(input logic [AW-1:0] head,
                                                input logic [CW-1:0] count);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(count);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        tail_slot = sum[AW-1:0];
    endfunction

    assign cat_full    = (r_cat_count == CW'(QUEUE_DEPTH));
    assign dog_full    = (r_dog_count == CW'(QUEUE_DEPTH));
    assign wr_cat      = i_cmd.add && (i_item_class == tcfam_pkg::CLASS_CAT) && !cat_full;
    assign wr_dog      = i_cmd.add && (i_item_class == tcfam_pkg::CLASS_DOG) && !dog_full;
    assign cat_wr_addr = tail_slot(r_cat_head, r_cat_count);
    assign dog_wr_addr = tail_slot(r_dog_head, r_dog_count);
    assign wr_data     = {r_arrival, i_item_value};

    assign n_cat_head  = i_cmd.pop_cat ? next_ptr(r_cat_head) : r_cat_head;
    assign n_dog_head  = i_cmd.pop_dog ? next_ptr(r_dog_head) : r_dog_head;
    assign n_cat_count = r_cat_count + CW'(wr_cat) - CW'(i_cmd.pop_cat);
    assign n_dog_count = r_dog_count + CW'(wr_dog) - CW'(i_cmd.pop_dog);

    // Reading at the next head keeps the registered read data on the current head.
    tcfam_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_cat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_cat),
        .i_wr_addr (cat_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_cat_head),
        .o_rd_data (cat_rd)
    );

    tcfam_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_dog_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_dog),
        .i_wr_addr (dog_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_dog_head),
        .o_rd_data (dog_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cat_head  <= '0;
            r_dog_head  <= '0;
            r_cat_count <= '0;
            r_dog_count <= '0;
            r_arrival   <= '0;
            r_overflow  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_cat_head  <= n_cat_head;
            r_dog_head  <= n_dog_head;
            r_cat_count <= n_cat_count;
            r_dog_count <= n_dog_count;
            if (wr_cat || wr_dog) begin
                r_arrival <= r_arrival + 1'b1;
            end
            if (i_cmd.add && !(wr_cat || wr_dog)) begin
                r_overflow <= 1'b1;
            end
            r_valid <= i_cmd.pop_cat || i_cmd.pop_dog || i_cmd.status_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result_kind   <= tcfam_pkg::RESULT_ENTRY;
        r_out_class     <= tcfam_pkg::CLASS_DOG;
        r_out_value     <= '0;
        r_last          <= i_cmd.last;
        r_both_empty    <= 1'b0;
        r_cat_empty     <= 1'b0;
        r_dog_empty     <= 1'b0;
        r_overflow_seen <= 1'b0;
        if (i_cmd.status_req) begin
            r_result_kind   <= tcfam_pkg::RESULT_STATUS;
            r_last          <= 1'b1;
            r_both_empty    <= (r_cat_count == '0) && (r_dog_count == '0);
            r_cat_empty     <= (r_cat_count == '0);
            r_dog_empty     <= (r_dog_count == '0);
            r_overflow_seen <= r_overflow;
        end else if (i_cmd.pop_cat) begin
            r_out_class <= tcfam_pkg::CLASS_CAT;
            r_out_value <= $signed(cat_rd[tcfam_pkg::ValueWidth-1:0]);
        end else if (i_cmd.pop_dog) begin
            r_out_value <= $signed(dog_rd[tcfam_pkg::ValueWidth-1:0]);
        end
    end

    assign o_stat.cat_empty = (r_cat_count == '0);
    assign o_stat.dog_empty = (r_dog_count == '0);
    assign o_stat.cat_one   = (r_cat_count == CW'(1));
    assign o_stat.dog_one   = (r_dog_count == CW'(1));
    assign o_stat.dog_older = $signed(dog_rd[DW-1:tcfam_pkg::ValueWidth]) <
                              $signed(cat_rd[DW-1:tcfam_pkg::ValueWidth]);

    assign o_valid           = r_valid;
    assign o_result_kind     = r_result_kind;
    assign o_out_class       = r_out_class;
    assign o_out_value       = r_out_value;
    assign o_last            = r_last;
    assign o_both_empty      = r_both_empty;
    assign o_cat_queue_empty = r_cat_empty;
    assign o_dog_queue_empty = r_dog_empty;
    assign o_overflow_seen   = r_overflow_seen;

`ifndef NO_ASSERTIONS
    a_cat_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cat_count <= CW'(QUEUE_DEPTH))
        else $error("cat queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop_cat |-> r_cat_count != '0) and (i_cmd.pop_dog |-> r_dog_count != '0))
        else $error("pop from an empty queue");

    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.pop_cat && i_cmd.pop_dog))
        else $error("both queues popped in one cycle");

    a_pop_gives_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop_cat || i_cmd.pop_dog) |=> (r_valid && r_result_kind == tcfam_pkg::RESULT_ENTRY))
        else $error("pop did not produce an entry beat");
`endif

endmodule

[tb/tcfam_checker.sv]
// Checker for the two-class FIFO unit: mirrors both queues and compares result beats.
module tcfam_checker #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [tcfam_pkg::KindWidth-1:0]   i_kind,
    input  logic                              i_class,
    input  logic [tcfam_pkg::ValueWidth-1:0]  i_value,
    input  logic                              i_valid,
    input  logic                              i_result_kind,
    input  logic                              i_out_class,
    input  logic [tcfam_pkg::ValueWidth-1:0]  i_out_value,
    input  logic                              i_last,
    input  logic                              i_both_empty,
    input  logic                              i_cat_empty,
    input  logic                              i_dog_empty,
    input  logic                              i_overflow,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_cmd_count,
    output int                                o_beat_count,
    output int                                o_drop_count
);
    import tcfam_pkg::*;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic [TagWidth-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic                  result_kind;
        logic                  out_class;
        logic [ValueWidth-1:0] out_value;
        logic                  last;
        logic                  both_empty;
        logic                  cat_empty;
        logic                  dog_empty;
        logic                  overflow;
    } t_beat;

    t_entry              dog_q[$];
    t_entry              cat_q[$];
    t_beat               beats_due[$];
    logic [TagWidth-1:0] arrival = '0;
    logic                sticky_overflow = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_cmd_count  = 0;
        o_beat_count = 0;
        o_drop_count = 0;
    end

    function automatic t_beat entry_beat(logic cls, t_entry e);
        t_beat b;
        b = '0;
        b.result_kind = RESULT_ENTRY;
        b.out_class   = cls;
        b.out_value   = e.value;
        return b;
    endfunction

    task automatic pop_dog();
        beats_due.push_back(entry_beat(CLASS_DOG, dog_q.pop_front()));
    endtask

    task automatic pop_cat();
        beats_due.push_back(entry_beat(CLASS_CAT, cat_q.pop_front()));
    endtask

    // Works out the beats one accepted command produces and updates the queues.
    task automatic predict_command(logic [KindWidth-1:0] kind, logic cls,
                                   logic [ValueWidth-1:0] value);
        int    first;
        t_beat b;
        first = beats_due.size();
        case (kind)
            KIND_ADD: begin
                if (cls == CLASS_CAT && cat_q.size() < QUEUE_DEPTH) begin
                    cat_q.push_back(t_entry'{value: value, tag: arrival});
                    arrival++;
                end else if (cls == CLASS_DOG && dog_q.size() < QUEUE_DEPTH) begin
                    dog_q.push_back(t_entry'{value: value, tag: arrival});
                    arrival++;
                end else begin
                    // A full queue drops the add without using an arrival number.
                    sticky_overflow = 1'b1;
                    o_drop_count++;
                end
            end
            KIND_DRAIN_ALL: begin
                // The dog head leaves first only when its tag is strictly older.
                while (cat_q.size() > 0 && dog_q.size() > 0) begin
                    if ($signed(dog_q[0].tag) < $signed(cat_q[0].tag)) pop_dog();
                    else pop_cat();
                end
                while (dog_q.size() > 0) pop_dog();
                while (cat_q.size() > 0) pop_cat();
            end
            KIND_DRAIN_CAT: while (cat_q.size() > 0) pop_cat();
            KIND_DRAIN_DOG: while (dog_q.size() > 0) pop_dog();
            KIND_STATUS: begin
                b = '0;
                b.result_kind = RESULT_STATUS;
                b.both_empty  = (cat_q.size() == 0) && (dog_q.size() == 0);
                b.cat_empty   = (cat_q.size() == 0);
                b.dog_empty   = (dog_q.size() == 0);
                b.overflow    = sticky_overflow;
                beats_due.push_back(b);
            end
            default: ;
        endcase
        if (beats_due.size() > first) begin
            b = beats_due.pop_back();
            b.last = 1'b1;
            beats_due.push_back(b);
        end
    endtask

    task automatic compare_field(string name, logic [ValueWidth-1:0] want,
                                 logic [ValueWidth-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_beat();
        t_beat want;
        t_beat got;
        got = {i_result_kind, i_out_class, i_out_value, i_last,
               i_both_empty, i_cat_empty, i_dog_empty, i_overflow};
        o_beat_count++;
        if (beats_due.size() == 0) begin
            o_fail_count++;
            $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        end else begin
            want = beats_due.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("out_class", want.out_class, got.out_class);
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("last", want.last, got.last);
            compare_field("both_empty", want.both_empty, got.both_empty);
            compare_field("cat_queue_empty", want.cat_empty, got.cat_empty);
            compare_field("dog_queue_empty", want.dog_empty, got.dog_empty);
            compare_field("overflow_seen", want.overflow, got.overflow);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dog_q.delete();
            cat_q.delete();
            beats_due.delete();
            arrival         = '0;
            sticky_overflow = 1'b0;
        end else begin
            // A beat seen now always belongs to a command accepted earlier.
            if (i_valid) check_beat();
            if (i_start && !i_busy) begin
                o_cmd_count++;
                predict_command(i_kind, i_class, i_value);
            end
        end
        o_pending = beats_due.size();
    end

endmodule

[tb/testbench.sv]
// Testbench top for the two-class FIFO unit: clock, reset, command stimulus and verdict.
module testbench;
    import tcfam_pkg::*;

    localparam int QueueDepth  = 32;
    localparam int RandomItems = 380;
    localparam int QuietTail   = 60;
    localparam int DrainCycles = 2 * QueueDepth + 16;

    localparam logic [ValueWidth-1:0] MinValue = 32'h8000_0000;
    localparam logic [ValueWidth-1:0] MaxValue = 32'h7fff_ffff;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [KindWidth-1:0]         i_kind;
    logic                         i_item_class;
    logic signed [ValueWidth-1:0] i_item_value;
    logic                         o_valid;
    logic                         o_result_kind;
    logic                         o_out_class;
    logic signed [ValueWidth-1:0] o_out_value;
    logic                         o_last;
    logic                         o_both_empty;
    logic                         o_cat_queue_empty;
    logic                         o_dog_queue_empty;
    logic                         o_overflow_seen;

    int fail_count;
    int pending;
    int cmd_count;
    int beat_count;
    int drop_count;

    two_class_fifo_age_merge_unit #(
        .QUEUE_DEPTH(QueueDepth)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_item_class     (i_item_class),
        .i_item_value     (i_item_value),
        .o_valid          (o_valid),
        .o_result_kind    (o_result_kind),
        .o_out_class      (o_out_class),
        .o_out_value      (o_out_value),
        .o_last           (o_last),
        .o_both_empty     (o_both_empty),
        .o_cat_queue_empty(o_cat_queue_empty),
        .o_dog_queue_empty(o_dog_queue_empty),
        .o_overflow_seen  (o_overflow_seen)
    );

    tcfam_checker #(
        .QUEUE_DEPTH(QueueDepth)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (i_kind),
        .i_class      (i_item_class),
        .i_value      (i_item_value),
        .i_valid      (o_valid),
        .i_result_kind(o_result_kind),
        .i_out_class  (o_out_class),
        .i_out_value  (o_out_value),
        .i_last       (o_last),
        .i_both_empty (o_both_empty),
        .i_cat_empty  (o_cat_queue_empty),
        .i_dog_empty  (o_dog_queue_empty),
        .i_overflow   (o_overflow_seen),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_cmd_count  (cmd_count),
        .o_beat_count (beat_count),
        .o_drop_count (drop_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("two_class_fifo_age_merge_unit verification failed");
        $finish;
    end

    function automatic logic [ValueWidth-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return MinValue;
            1: return MaxValue;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Drives one command and returns once the block has taken it.
    task automatic issue(logic [KindWidth-1:0] kind, logic cls, logic [ValueWidth-1:0] value);
        @(negedge i_clk);
        start        <= 1'b1;
        i_kind       <= kind;
        i_item_class <= cls;
        i_item_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle(logic allowed);
        if (allowed && $urandom_range(0, 4) == 0) pause($urandom_range(1, 16));
    endtask

    initial begin
        int                   sent;
        int                   seg_len;
        int                   pick;
        logic                 cls;
        logic                 idle_ok;
        logic [KindWidth-1:0] kind;

        start        = 1'b0;
        i_kind       = KIND_ADD;
        i_item_class = CLASS_DOG;
        i_item_value = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty drains, value extremes, merge order and ignored codes.
        issue(KIND_STATUS, CLASS_DOG, '0);
        issue(KIND_DRAIN_ALL, CLASS_CAT, '1);
        issue(KIND_DRAIN_CAT, CLASS_DOG, '0);
        issue(KIND_DRAIN_DOG, CLASS_CAT, '0);
        issue(KIND_ADD, CLASS_DOG, MinValue);
        issue(KIND_ADD, CLASS_CAT, MaxValue);
        issue(KIND_ADD, CLASS_DOG, '0);
        issue(KIND_ADD, CLASS_CAT, '1);
        issue(KIND_STATUS, CLASS_CAT, '1);
        issue(KIND_DRAIN_ALL, CLASS_DOG, '0);
        issue(KIND_ADD, CLASS_CAT, 32'h5555_5555);
        issue(KIND_ADD, CLASS_CAT, 32'haaaa_aaaa);
        issue(KIND_ADD, CLASS_DOG, 32'h1234_5678);
        issue(KIND_DRAIN_CAT, CLASS_DOG, '0);
        issue(KIND_STATUS, CLASS_DOG, '0);
        issue(KIND_DRAIN_DOG, CLASS_DOG, '0);
        issue(KIND_ADD, CLASS_DOG, 32'h0000_0001);
        for (int k = 1; k <= 3; k++) issue(KindWidth'(KIND_STATUS + k), CLASS_CAT, '1);
        issue(KIND_DRAIN_ALL, CLASS_CAT, '0);
        issue(KIND_ADD, CLASS_CAT, 32'h0000_0002);
        issue(KIND_ADD, CLASS_DOG, 32'h0000_0003);
        issue(KIND_DRAIN_ALL, CLASS_DOG, '0);

        // Random part: fill bursts that overrun a queue, mixed with general traffic.
        sent = 0;
        while (sent < RandomItems) begin
            idle_ok = (sent < RandomItems - QuietTail) && ($urandom_range(0, 3) != 0);
            if (sent == 0 || $urandom_range(0, 5) == 0) begin
                cls     = logic'($urandom_range(0, 1));
                seg_len = QueueDepth + $urandom_range(1, 3);
                repeat (seg_len) begin
                    issue(KIND_ADD, cls, rand_value());
                    maybe_idle(idle_ok);
                end
                issue(KIND_STATUS, logic'($urandom_range(0, 1)), rand_value());
                sent += seg_len + 1;
            end else begin
                seg_len = $urandom_range(8, 30);
                repeat (seg_len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55) kind = KIND_ADD;
                    else if (pick < 67) kind = KIND_DRAIN_ALL;
                    else if (pick < 75) kind = KIND_DRAIN_CAT;
                    else if (pick < 83) kind = KIND_DRAIN_DOG;
                    else if (pick < 95) kind = KIND_STATUS;
                    else kind = KindWidth'(KIND_STATUS + $urandom_range(1, 3));
                    issue(kind, logic'($urandom_range(0, 1)), rand_value());
                    if (kind <= KIND_STATUS) sent++;
                    maybe_idle(idle_ok);
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        $display("Run covered %0d accepted commands and %0d checked result beats,",
                 cmd_count, beat_count);
        $display("including %0d adds dropped on a full queue.", drop_count);
        if (fail_count == 0) begin
            $display("two_class_fifo_age_merge_unit verification clean");
        end else begin
            $display("two_class_fifo_age_merge_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/tcfam_pkg.sv
src/tcfam_ram.sv
src/tcfam_ctrl.sv
src/tcfam_dp.sv
src/two_class_fifo_age_merge_unit.sv
tb/tcfam_checker.sv
tb/testbench.sv
